// File: rtl/core/bep_pkg.sv
// Shared types, codes and tables for the bibliography entry parser.
package bep_pkg;

    typedef enum logic [4:0] {
        PH_SEEK        = 5'd0,
        PH_TYPE_SP     = 5'd1,
        PH_TYPE        = 5'd2,
        PH_SEEK_OPEN   = 5'd3,
        PH_TAG_SP      = 5'd4,
        PH_TAG         = 5'd5,
        PH_SEEK_DELIM  = 5'd6,
        PH_AFTER_COMMA = 5'd7,
        PH_KEY         = 5'd8,
        PH_SEEK_EQ     = 5'd9,
        PH_STR_OPEN    = 5'd10,
        PH_STR         = 5'd11,
        PH_NUM_SP      = 5'd12,
        PH_NUM_SP2     = 5'd13,
        PH_NUM         = 5'd14,
        PH_PEND_END    = 5'd15,
        PH_HALT        = 5'd16
    } phase_t;

    localparam logic [2:0] EV_TYPE   = 3'd0;
    localparam logic [2:0] EV_TAG    = 3'd1;
    localparam logic [2:0] EV_STRING = 3'd2;
    localparam logic [2:0] EV_NUMBER = 3'd3;
    localparam logic [2:0] EV_END    = 3'd4;
    localparam logic [2:0] EV_ERROR  = 3'd5;

    localparam logic [1:0] ERR_TRUNC   = 2'd0;
    localparam logic [1:0] ERR_EMPTY   = 2'd1;
    localparam logic [1:0] ERR_UNKNOWN = 2'd2;
    localparam logic [1:0] ERR_DEEP    = 2'd3;

    localparam logic [4:0] FIELD_YEAR    = 5'd13;
    localparam logic [4:0] FIELD_NUMBER  = 5'd15;
    localparam logic [4:0] FIELD_UNKNOWN = 5'd16;

    localparam int NUM_TYPES = 14;
    localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

    // Byte classes of one input item, computed by the front end.
    typedef struct packed {
        logic       eoi;
        logic [7:0] lc;
        logic       space;
        logic       digit;
        logic       alnum;
        logic       at;
        logic       lbrace;
        logic       rbrace;
        logic       comma;
        logic       equal;
        logic       quote;
        logic       newline;
    } item_t;

    function automatic logic [3:0] type_len(input int t);
        begin
            unique case (t)
                0, 2:      type_len = 4'd7;
                1, 9:      type_len = 4'd4;
                3, 12:     type_len = 4'd10;
                4, 7:      type_len = 4'd6;
                5:         type_len = 4'd12;
                6, 8:      type_len = 4'd13;
                10:        type_len = 4'd9;
                default:   type_len = 4'd11;
            endcase
        end
    endfunction

    // Type name byte at a given index, lowercase; zero past the end.
    function automatic logic [7:0] type_char(input int t, input logic [3:0] i);
        logic [103:0] s;
        int           n;
        begin
            unique case (t)
                0:  s = 104'("article");
                1:  s = 104'("book");
                2:  s = 104'("booklet");
                3:  s = 104'("conference");
                4:  s = 104'("inbook");
                5:  s = 104'("incollection");
                6:  s = 104'("inproceedings");
                7:  s = 104'("manual");
                8:  s = 104'("mastersthesis");
                9:  s = 104'("misc");
                10: s = 104'("phdthesis");
                11: s = 104'("proceedings");
                12: s = 104'("techreport");
                default: s = 104'("unpublished");
            endcase
            n = int'(type_len(t));
            if (int'(i) < n) begin
                type_char = s[8 * (n - 1 - int'(i)) +: 8];
            end else begin
                type_char = 8'd0;
            end
        end
    endfunction

    // Class a key by its first three lowercased bytes.
    function automatic logic [4:0] key_class(input logic [23:0] k, input logic [1:0] n);
        begin
            if (n != 2'd3) begin
                key_class = FIELD_UNKNOWN;
            end else begin
                unique case (k)
                    "tit":   key_class = 5'd0;
                    "aut":   key_class = 5'd1;
                    "edi":   key_class = 5'd2;
                    "ser":   key_class = 5'd3;
                    "org":   key_class = 5'd4;
                    "jou":   key_class = 5'd5;
                    "pub":   key_class = 5'd6;
                    "add":   key_class = 5'd7;
                    "how":   key_class = 5'd8;
                    "boo":   key_class = 5'd9;
                    "mon":   key_class = 5'd10;
                    "abs":   key_class = 5'd11;
                    "not":   key_class = 5'd11;
                    "pag":   key_class = 5'd12;
                    "yea":   key_class = 5'd13;
                    "vol":   key_class = 5'd14;
                    "num":   key_class = 5'd15;
                    default: key_class = FIELD_UNKNOWN;
                endcase
            end
        end
    endfunction

endpackage

// File: rtl/core/bibliography_entry_parser_top.sv
// Top level of the bibliography entry parser.
// Usage: feed one source byte per transfer on the s_ channel (s_text_byte),
// or a transfer with s_end_of_input high to close the source. Each input
// transfer yields zero or one event on the m_ channel: type, tag, string
// field, number field, entry end, or error with its code.
// Throughput: one byte per cycle while results are accepted; the parse state
// updates once per byte and a two-entry queue separates the byte classifier
// from the parser, whose events are registered in the result register.
// When the receiver stalls, the result register holds, the parser stops
// once the register is full, and the queue fills and then drops s_ready.
// Reset (aresetn low, synchronous) empties queue and result register and
// puts the parser into the seek-for-at-sign state with offsets at zero.
// After an error, bytes are ignored until an end-of-input transfer.
module bibliography_entry_parser_top #(
    parameter int OFFSET_BITS = 32,
    parameter int DEPTH_BITS  = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    input  logic        s_end_of_input,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_res,
    output logic [3:0]  m_entry_type,
    output logic [4:0]  m_field_id,
    output logic [31:0] m_span_start,
    output logic [31:0] m_span_length,
    output logic [30:0] m_number_value,
    output logic [31:0] m_line_number,
    output logic [31:0] m_position,
    output logic [1:0]  m_error_code
);

    logic           q_valid;
    logic           q_ready;
    bep_pkg::item_t q_item;

    bep_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_text_byte    (s_text_byte),
        .s_end_of_input (s_end_of_input),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_item         (q_item)
    );

    bep_back #(
        .OFFSET_BITS (OFFSET_BITS),
        .DEPTH_BITS  (DEPTH_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_item         (q_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_res    (m_event_res),
        .m_entry_type   (m_entry_type),
        .m_field_id     (m_field_id),
        .m_span_start   (m_span_start),
        .m_span_length  (m_span_length),
        .m_number_value (m_number_value),
        .m_line_number  (m_line_number),
        .m_position     (m_position),
        .m_error_code   (m_error_code)
    );

endmodule

// File: rtl/core/bep_front.sv
// Front end: accepts bytes, classifies them and queues them for the parser.
module bep_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_text_byte,
    input  logic            s_end_of_input,
    output logic            q_valid,
    input  logic            q_ready,
    output bep_pkg::item_t  q_item
);

    bep_pkg::item_t slot_reg [2];
    logic [1:0]     count_reg;
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    bep_pkg::item_t cls;
    logic           push;
    logic           pop;
    logic [7:0]     b;

    // Classify the incoming byte
    always_comb begin
        b           = s_text_byte;
        cls.eoi     = s_end_of_input;
        cls.lc      = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
        cls.space   = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
        cls.digit   = (b >= "0" && b <= "9");
        cls.alnum   = cls.digit || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
        cls.at      = (b == "@");
        cls.lbrace  = (b == "{");
        cls.rbrace  = (b == "}");
        cls.comma   = (b == ",");
        cls.equal   = (b == "=");
        cls.quote   = (b == 8'h22);
        cls.newline = (b == 8'h0A);
    end

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_item  = slot_reg[rd_ptr_reg];

    // Two-entry queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= cls;
    end

    property p_no_overflow;
        @(posedge aclk) disable iff (!aresetn) count_reg <= 2'd2;
    endproperty
    a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

    property p_pop_nonempty;
        @(posedge aclk) disable iff (!aresetn) pop |-> count_reg != 2'd0;
    endproperty
    a_pop_nonempty: assert property (p_pop_nonempty) else $error("pop from empty");

    property p_full_stall;
        @(posedge aclk) disable iff (!aresetn) (count_reg == 2'd2) |-> !s_ready;
    endproperty
    a_full_stall: assert property (p_full_stall) else $error("ready while full");

endmodule

// File: rtl/core/bep_back.sv
// Back end: the parse state machine and the registered result stage.
module bep_back #(
    parameter int OFFSET_BITS = 32,
    parameter int DEPTH_BITS  = 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    output logic            q_ready,
    input  bep_pkg::item_t  q_item,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [2:0]      m_event_res,
    output logic [3:0]      m_entry_type,
    output logic [4:0]      m_field_id,
    output logic [31:0]     m_span_start,
    output logic [31:0]     m_span_length,
    output logic [30:0]     m_number_value,
    output logic [31:0]     m_line_number,
    output logic [31:0]     m_position,
    output logic [1:0]      m_error_code
);

    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

    bep_pkg::phase_t           phase_reg, phase_next;
    logic [OFFSET_BITS-1:0]    off_reg, off_next;
    logic [31:0]               nl_reg, nl_next;
    logic [DEPTH_BITS-1:0]     depth_reg, depth_next;
    logic [13:0]               cand_reg, cand_next;
    logic [3:0]                wc_reg, wc_next;
    logic [23:0]               kp_reg, kp_next;
    logic [1:0]                pc_reg, pc_next;
    logic [4:0]                fld_reg, fld_next;
    logic [OFFSET_BITS-1:0]    sb_reg, sb_next;
    logic [30:0]               acc_reg, acc_next;
    logic                      qm_reg, qm_next;

    logic                      ov_reg;
    logic [2:0]                oev_reg;
    logic [3:0]                oty_reg;
    logic [4:0]                ofl_reg;
    logic [31:0]               ost_reg, oln_reg, onl_reg, opos_reg;
    logic [30:0]               onum_reg;
    logic [1:0]                oerr_reg;

    logic                      emit;
    logic [2:0]                ev;
    logic [3:0]                ety;
    logic [4:0]                efl;
    logic [OFFSET_BITS-1:0]    est, eln, epos;
    logic [30:0]               enum_v;
    logic [1:0]                eerr;
    logic                      step;
    logic [13:0]               cand_fed;
    logic [13:0]               cand_src;
    logic [3:0]                wc_src;
    logic [3:0]                match_idx;
    logic                      match_any;
    logic [34:0]               acc_wide;
    logic [OFFSET_BITS-1:0]    slen;
    logic                      closed;
    logic [4:0]                fcls;

    // Accept a queued byte when the result register is free or draining
    assign q_ready = !ov_reg || m_ready;
    assign step    = q_valid && q_ready;

    // Type candidate filter
    always_comb begin
        cand_src = (phase_reg == bep_pkg::PH_TYPE_SP) ? 14'h3FFF : cand_reg;
        wc_src   = (phase_reg == bep_pkg::PH_TYPE_SP) ? 4'd0 : wc_reg;
        for (int t = 0; t < bep_pkg::NUM_TYPES; t++) begin
            cand_fed[t] = cand_src[t] && (wc_src < bep_pkg::type_len(t)) &&
                          (bep_pkg::type_char(t, wc_src) == q_item.lc);
        end
        match_idx = 4'd0;
        match_any = 1'b0;
        for (int t = bep_pkg::NUM_TYPES - 1; t >= 0; t--) begin
            if (cand_reg[t] && bep_pkg::type_len(t) == wc_reg) begin
                match_idx = 4'(t);
                match_any = 1'b1;
            end
        end
    end

    assign acc_wide = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                      + {31'd0, q_item.lc[3:0]};
    assign slen     = off_reg - sb_reg;
    assign fcls     = bep_pkg::key_class(kp_reg, pc_reg);

    // Next state and event selection
    always_comb begin
        phase_next = phase_reg;
        off_next   = off_reg;
        nl_next    = nl_reg;
        depth_next = depth_reg;
        cand_next  = cand_reg;
        wc_next    = wc_reg;
        kp_next    = kp_reg;
        pc_next    = pc_reg;
        fld_next   = fld_reg;
        sb_next    = sb_reg;
        acc_next   = acc_reg;
        qm_next    = qm_reg;
        emit       = 1'b0;
        ev         = bep_pkg::EV_ERROR;
        ety        = 4'd0;
        efl        = 5'd0;
        est        = '0;
        eln        = '0;
        enum_v     = 31'd0;
        eerr       = 2'd0;
        epos       = off_reg;
        closed     = 1'b0;
        if (q_item.eoi) begin
            if (phase_reg == bep_pkg::PH_PEND_END) begin
                emit = 1'b1;
                ev   = bep_pkg::EV_END;
                epos = sb_reg;
            end else if (phase_reg != bep_pkg::PH_SEEK && phase_reg != bep_pkg::PH_HALT) begin
                emit = 1'b1;
                eerr = bep_pkg::ERR_TRUNC;
            end
            phase_next = bep_pkg::PH_SEEK;
            off_next   = '0;
            nl_next    = 32'd0;
            depth_next = '0;
            cand_next  = 14'h3FFF;
            wc_next    = 4'd0;
            kp_next    = 24'd0;
            pc_next    = 2'd0;
            fld_next   = 5'd0;
            sb_next    = '0;
            acc_next   = 31'd0;
            qm_next    = 1'b0;
        end else begin
            off_next = off_reg + 1'b1;
            if (q_item.newline) nl_next = nl_reg + 32'd1;
            unique case (phase_reg)
                bep_pkg::PH_PEND_END: begin
                    emit = 1'b1;
                    ev   = bep_pkg::EV_END;
                    epos = sb_reg;
                    phase_next = q_item.at ? bep_pkg::PH_TYPE_SP : bep_pkg::PH_SEEK;
                end
                bep_pkg::PH_SEEK: begin
                    if (q_item.at) phase_next = bep_pkg::PH_TYPE_SP;
                end
                bep_pkg::PH_TYPE_SP: begin
                    if (!q_item.space) begin
                        if (!q_item.alnum) begin
                            emit = 1'b1;
                            eerr = bep_pkg::ERR_EMPTY;
                            phase_next = bep_pkg::PH_HALT;
                        end else begin
                            cand_next  = cand_fed;
                            wc_next    = 4'd1;
                            phase_next = bep_pkg::PH_TYPE;
                        end
                    end
                end
                bep_pkg::PH_TYPE: begin
                    if (q_item.alnum) begin
                        cand_next = cand_fed;
                        if (wc_reg != 4'd15) wc_next = wc_reg + 4'd1;
                    end else if (!match_any) begin
                        emit = 1'b1;
                        eerr = bep_pkg::ERR_UNKNOWN;
                        phase_next = bep_pkg::PH_HALT;
                    end else begin
                        emit = 1'b1;
                        ev   = bep_pkg::EV_TYPE;
                        ety  = match_idx;
                        phase_next = q_item.lbrace ? bep_pkg::PH_TAG_SP
                                                   : bep_pkg::PH_SEEK_OPEN;
                    end
                end
                bep_pkg::PH_SEEK_OPEN: begin
                    if (q_item.lbrace) phase_next = bep_pkg::PH_TAG_SP;
                end
                bep_pkg::PH_TAG_SP: begin
                    if (!q_item.space) begin
                        if (!q_item.alnum) begin
                            emit = 1'b1;
                            eerr = bep_pkg::ERR_EMPTY;
                            phase_next = bep_pkg::PH_HALT;
                        end else begin
                            sb_next    = off_reg;
                            phase_next = bep_pkg::PH_TAG;
                        end
                    end
                end
                bep_pkg::PH_TAG: begin
                    if (!q_item.alnum) begin
                        emit = 1'b1;
                        ev   = bep_pkg::EV_TAG;
                        est  = sb_reg;
                        eln  = slen;
                        if (q_item.comma) begin
                            phase_next = bep_pkg::PH_AFTER_COMMA;
                        end else if (q_item.rbrace) begin
                            sb_next    = off_reg;
                            phase_next = bep_pkg::PH_PEND_END;
                        end else begin
                            phase_next = bep_pkg::PH_SEEK_DELIM;
                        end
                    end
                end
                bep_pkg::PH_SEEK_DELIM: begin
                    if (q_item.comma) begin
                        phase_next = bep_pkg::PH_AFTER_COMMA;
                    end else if (q_item.rbrace) begin
                        emit = 1'b1;
                        ev   = bep_pkg::EV_END;
                        phase_next = bep_pkg::PH_SEEK;
                    end
                end
                bep_pkg::PH_AFTER_COMMA: begin
                    if (!q_item.space) begin
                        if (q_item.rbrace) begin
                            emit = 1'b1;
                            ev   = bep_pkg::EV_END;
                            phase_next = bep_pkg::PH_SEEK;
                        end else if (!q_item.alnum) begin
                            emit = 1'b1;
                            eerr = bep_pkg::ERR_EMPTY;
                            phase_next = bep_pkg::PH_HALT;
                        end else begin
                            kp_next    = {16'd0, q_item.lc};
                            pc_next    = 2'd1;
                            phase_next = bep_pkg::PH_KEY;
                        end
                    end
                end
                bep_pkg::PH_KEY: begin
                    if (q_item.alnum) begin
                        if (pc_reg != 2'd3) begin
                            kp_next = {kp_reg[15:0], q_item.lc};
                            pc_next = pc_reg + 2'd1;
                        end
                    end else begin
                        fld_next = fcls;
                        if (q_item.equal) begin
                            phase_next = (fcls >= bep_pkg::FIELD_YEAR &&
                                          fcls <= bep_pkg::FIELD_NUMBER)
                                         ? bep_pkg::PH_NUM_SP : bep_pkg::PH_STR_OPEN;
                        end else begin
                            phase_next = bep_pkg::PH_SEEK_EQ;
                        end
                    end
                end
                bep_pkg::PH_SEEK_EQ: begin
                    if (q_item.equal) begin
                        phase_next = (fld_reg >= bep_pkg::FIELD_YEAR &&
                                      fld_reg <= bep_pkg::FIELD_NUMBER)
                                     ? bep_pkg::PH_NUM_SP : bep_pkg::PH_STR_OPEN;
                    end
                end
                bep_pkg::PH_STR_OPEN: begin
                    if (q_item.quote || q_item.lbrace) begin
                        qm_next    = q_item.quote;
                        depth_next = DEPTH_BITS'(1);
                        sb_next    = off_reg + 1'b1;
                        phase_next = bep_pkg::PH_STR;
                    end
                end
                bep_pkg::PH_STR: begin
                    if (qm_reg) begin
                        closed = q_item.quote;
                    end else if (q_item.lbrace) begin
                        if (depth_reg == DEPTH_MAX) begin
                            emit = 1'b1;
                            eerr = bep_pkg::ERR_DEEP;
                            phase_next = bep_pkg::PH_HALT;
                        end else begin
                            depth_next = depth_reg + 1'b1;
                        end
                    end else if (q_item.rbrace) begin
                        depth_next = depth_reg - 1'b1;
                        closed     = (depth_reg == DEPTH_BITS'(1));
                    end
                    if (closed) begin
                        emit = 1'b1;
                        if (slen == '0) begin
                            eerr = bep_pkg::ERR_EMPTY;
                            phase_next = bep_pkg::PH_HALT;
                        end else begin
                            ev   = bep_pkg::EV_STRING;
                            efl  = fld_reg;
                            est  = sb_reg;
                            eln  = slen;
                            phase_next = bep_pkg::PH_SEEK_DELIM;
                        end
                    end
                end
                bep_pkg::PH_NUM_SP, bep_pkg::PH_NUM_SP2: begin
                    if (!q_item.space) begin
                        if (q_item.lbrace && phase_reg == bep_pkg::PH_NUM_SP) begin
                            phase_next = bep_pkg::PH_NUM_SP2;
                        end else if (!q_item.digit) begin
                            emit = 1'b1;
                            eerr = bep_pkg::ERR_EMPTY;
                            phase_next = bep_pkg::PH_HALT;
                        end else begin
                            acc_next   = {27'd0, q_item.lc[3:0]};
                            phase_next = bep_pkg::PH_NUM;
                        end
                    end
                end
                bep_pkg::PH_NUM: begin
                    if (q_item.digit) begin
                        acc_next = (acc_wide > {4'd0, bep_pkg::NUM_MAX})
                                   ? bep_pkg::NUM_MAX : acc_wide[30:0];
                    end else begin
                        emit   = 1'b1;
                        ev     = bep_pkg::EV_NUMBER;
                        efl    = fld_reg;
                        enum_v = acc_reg;
                        phase_next = q_item.comma ? bep_pkg::PH_AFTER_COMMA
                                                  : bep_pkg::PH_SEEK_DELIM;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Advance parse state on each transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= bep_pkg::PH_SEEK;
            off_reg   <= '0;
            nl_reg    <= 32'd0;
            depth_reg <= '0;
            cand_reg  <= 14'h3FFF;
            wc_reg    <= 4'd0;
            kp_reg    <= 24'd0;
            pc_reg    <= 2'd0;
            fld_reg   <= 5'd0;
            sb_reg    <= '0;
            acc_reg   <= 31'd0;
            qm_reg    <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            off_reg   <= off_next;
            nl_reg    <= nl_next;
            depth_reg <= depth_next;
            cand_reg  <= cand_next;
            wc_reg    <= wc_next;
            kp_reg    <= kp_next;
            pc_reg    <= pc_next;
            fld_reg   <= fld_next;
            sb_reg    <= sb_next;
            acc_reg   <= acc_next;
            qm_reg    <= qm_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (step) begin
            ov_reg <= emit;
        end else if (m_ready) begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && emit) begin
            oev_reg  <= ev;
            oty_reg  <= ety;
            ofl_reg  <= efl;
            ost_reg  <= 32'(est);
            oln_reg  <= 32'(eln);
            onum_reg <= enum_v;
            onl_reg  <= q_item.eoi ? nl_reg : nl_next;
            opos_reg <= 32'(epos);
            oerr_reg <= eerr;
        end
    end

    assign m_valid        = ov_reg;
    assign m_event_res    = oev_reg;
    assign m_entry_type   = oty_reg;
    assign m_field_id     = ofl_reg;
    assign m_span_start   = ost_reg;
    assign m_span_length  = oln_reg;
    assign m_number_value = onum_reg;
    assign m_line_number  = onl_reg;
    assign m_position     = opos_reg;
    assign m_error_code   = oerr_reg;

    property p_hold_result;
        @(posedge aclk) disable iff (!aresetn)
            (m_valid && !m_ready) |=> m_valid && $stable(m_position);
    endproperty
    a_hold_result: assert property (p_hold_result) else $error("result dropped");

    property p_halt_stays;
        @(posedge aclk) disable iff (!aresetn)
            (step && phase_reg == bep_pkg::PH_HALT && !q_item.eoi) |-> !emit;
    endproperty
    a_halt_stays: assert property (p_halt_stays) else $error("event after error");

    property p_eoi_resets;
        @(posedge aclk) disable iff (!aresetn)
            (step && q_item.eoi) |=> phase_reg == bep_pkg::PH_SEEK && off_reg == '0;
    endproperty
    a_eoi_resets: assert property (p_eoi_resets) else $error("no reset at end");

endmodule
